// File: design/rfsd_pkg.sv
package rfsd_pkg;

  // frame delimiter and the good checksum total
  localparam logic [7:0] DELIMITER = 8'h7E;
  localparam logic [7:0] SUM_GOOD  = 8'hFF;

  // data offsets of the captured fields
  localparam int ID_OFFSET  = 12;
  localparam int ONE_OFFSET = 16;
  localparam int TWO_OFFSET = 21;
  localparam int BAT_OFFSET = 31;

  // result status codes
  localparam logic [2:0] ST_RECORD   = 3'd0;
  localparam logic [2:0] ST_CHECKSUM = 3'd1;
  localparam logic [2:0] ST_TYPE     = 3'd2;
  localparam logic [2:0] ST_LENGTH   = 3'd3;
  localparam logic [2:0] ST_BAD_ID   = 3'd4;
  localparam logic [2:0] ST_OVERLONG = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_TYPE    = 2'd0;
  localparam logic [1:0] REG_RECORD_LENGTH = 2'd1;
  localparam logic [1:0] REG_ID_LIMIT      = 2'd2;

  localparam int CFG_DATA_W = 9;

  typedef struct packed {
    logic [7:0] expected_frame_type;
    logic [6:0] expected_record_length;
    logic [8:0] sensor_id_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  frame_status;
    logic [7:0]  sensor_number;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [31:0] battery_value;
  } result_t;

  // replace one byte lane of a little-endian word
  function automatic logic [31:0] put_byte(logic [31:0] word, logic [1:0] rel,
                                           logic [7:0] b);
    logic [31:0] r;
    r = word;
    r[rel*8 +: 8] = b;
    return r;
  endfunction

endpackage

// File: design/rfsd_if.sv
interface rfsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface rfsd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_status;
  logic [7:0]  sensor_number;
  logic [31:0] first_value;
  logic [31:0] second_value;
  logic [31:0] battery_value;

  modport source(output valid, output frame_status, output sensor_number,
                 output first_value, output second_value, output battery_value,
                 input ready);
  modport sink(input valid, input frame_status, input sensor_number,
               input first_value, input second_value, input battery_value,
               output ready);
endinterface

// File: design/radio_frame_sensor_decoder.sv
// Radio sensor frame decoder.
// rx takes one received serial byte per beat (valid/ready). The decoder hunts
// for the 0x7E delimiter, reads a big-endian 16-bit length, sums the data and
// checksum bytes and checks type, length and sensor id.
// res gives one beat per finished frame: a status and, for a good record, the
// sensor id and three raw little-endian 32-bit words. Zero-length frames give
// no beat; a length above MAX_FRAME_BYTES - 4 gives an overlong beat at once.
// Throughput is one byte per clock while res does not stall: each byte is held in
// the input register while the parser state updates from it; a result reaches res
// through the result register once the checksum byte has stepped the parser.
// When res stalls, the parser holds; the input register still takes one more
// byte, after which rx.ready follows res.ready.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered and must be
// only made while no frame is in progress; the block does not enforce this.
// Reset (rst, synchronous) empties both registers, sets hunting and loads the
// default register values.
module radio_frame_sensor_decoder #(
  parameter int MAX_FRAME_BYTES = 100
) (
  input  logic                            clk,
  input  logic                            rst,
  rfsd_byte_if.sink                       rx,
  rfsd_result_if.source                   res,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [rfsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  rfsd_pkg::cfg_t    cfg;
  rfsd_pkg::result_t parse_res;
  rfsd_pkg::result_t out_data;
  logic              parse_fire;
  logic              byte_valid;
  logic [7:0]        byte_data;
  logic              out_valid;
  logic              out_free;
  logic              step;

  rfsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake: parse when the output register can take a result
  assign out_free = !out_valid || res.ready;
  assign step     = byte_valid && out_free;
  assign rx.ready = !byte_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      byte_valid <= 1'b1;
    end else if (step) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_data <= rx.rx_byte;
    end
  end

  rfsd_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (byte_data),
    .cfg      (cfg),
    .res_fire (parse_fire),
    .res      (parse_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (parse_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (parse_fire) begin
      out_data <= parse_res;
    end
  end

  assign res.valid         = out_valid;
  assign res.frame_status  = out_data.frame_status;
  assign res.sensor_number = out_data.sensor_number;
  assign res.first_value   = out_data.first_value;
  assign res.second_value  = out_data.second_value;
  assign res.battery_value = out_data.battery_value;

  // a byte waiting on a stalled result is kept intact
  a_byte_held: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !out_free |=> byte_valid && $stable(byte_data))
    else $error("pending byte lost during result stall");

endmodule

// File: design/rfsd_cfg_regs.sv
module rfsd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [rfsd_pkg::CFG_DATA_W-1:0] cfg_data,
  output rfsd_pkg::cfg_t                 cfg
);

  // register writes, reset to the sensor frame defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_frame_type    <= 8'd144;
      cfg.expected_record_length <= 7'd36;
      cfg.sensor_id_limit        <= 9'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfsd_pkg::REG_FRAME_TYPE:    cfg.expected_frame_type    <= cfg_data[7:0];
        rfsd_pkg::REG_RECORD_LENGTH: cfg.expected_record_length <= cfg_data[6:0];
        rfsd_pkg::REG_ID_LIMIT:      cfg.sensor_id_limit        <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/rfsd_parser.sv
module rfsd_parser #(
  parameter int MAX_FRAME_BYTES = 100
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  rfsd_pkg::cfg_t    cfg,
  output logic              res_fire,
  output rfsd_pkg::result_t res
);

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES - 3);
  localparam logic [7:0] LEN_LIMIT = 8'(MAX_FRAME_BYTES - 4);

  localparam logic [1:0] HUNT   = 2'd0;
  localparam logic [1:0] LEN_HI = 2'd1;
  localparam logic [1:0] LEN_LO = 2'd2;
  localparam logic [1:0] DATA   = 2'd3;

  logic [1:0]       state, state_next;
  logic             hi_nz, hi_nz_next;
  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] idx, idx_next;
  logic [7:0]       sum, sum_next;
  logic [7:0]       type_b, type_next;
  logic [7:0]       id_b, id_next;
  logic [31:0]      w1, w1_next;
  logic [31:0]      w2, w2_next;
  logic [31:0]      wb, wb_next;
  logic [2:0]       status;

  // status of a finished frame, checked in priority order
  always_comb begin
    priority if (sum_next != rfsd_pkg::SUM_GOOD)
      status = rfsd_pkg::ST_CHECKSUM;
    else if (type_next != cfg.expected_frame_type)
      status = rfsd_pkg::ST_TYPE;
    else if (7'(len) != cfg.expected_record_length)
      status = rfsd_pkg::ST_LENGTH;
    else if ({1'b0, id_next} >= cfg.sensor_id_limit)
      status = rfsd_pkg::ST_BAD_ID;
    else
      status = rfsd_pkg::ST_RECORD;
  end

  // next state, captures and result
  always_comb begin
    state_next = state;
    hi_nz_next = hi_nz;
    len_next   = len;
    idx_next   = idx;
    sum_next   = sum;
    type_next  = type_b;
    id_next    = id_b;
    w1_next    = w1;
    w2_next    = w2;
    wb_next    = wb;
    res_fire   = 1'b0;
    res        = '0;
    unique case (state)
      HUNT: begin
        if (rx_byte == rfsd_pkg::DELIMITER) begin
          state_next = LEN_HI;
          sum_next   = '0;
          type_next  = '0;
          id_next    = '0;
          w1_next    = '0;
          w2_next    = '0;
          wb_next    = '0;
        end
      end
      LEN_HI: begin
        hi_nz_next = (rx_byte != 8'd0);
        state_next = LEN_LO;
      end
      LEN_LO: begin
        if (!hi_nz && rx_byte == 8'd0) begin
          state_next = HUNT;
        end else if (hi_nz || rx_byte > LEN_LIMIT) begin
          state_next       = HUNT;
          res_fire         = step;
          res.frame_status = rfsd_pkg::ST_OVERLONG;
        end else begin
          len_next   = rx_byte[LEN_W-1:0];
          idx_next   = '0;
          state_next = DATA;
        end
      end
      DATA: begin
        sum_next = sum + rx_byte;
        if (idx == LEN_W'(0))
          type_next = rx_byte;
        else if (idx == LEN_W'(rfsd_pkg::ID_OFFSET))
          id_next = rx_byte;
        else if (idx >= LEN_W'(rfsd_pkg::ONE_OFFSET) &&
                 idx <  LEN_W'(rfsd_pkg::ONE_OFFSET + 4))
          w1_next = rfsd_pkg::put_byte(w1, 2'(idx - LEN_W'(rfsd_pkg::ONE_OFFSET)),
                                       rx_byte);
        else if (idx >= LEN_W'(rfsd_pkg::TWO_OFFSET) &&
                 idx <  LEN_W'(rfsd_pkg::TWO_OFFSET + 4))
          w2_next = rfsd_pkg::put_byte(w2, 2'(idx - LEN_W'(rfsd_pkg::TWO_OFFSET)),
                                       rx_byte);
        else if (idx >= LEN_W'(rfsd_pkg::BAT_OFFSET) &&
                 idx <  LEN_W'(rfsd_pkg::BAT_OFFSET + 4))
          wb_next = rfsd_pkg::put_byte(wb, 2'(idx - LEN_W'(rfsd_pkg::BAT_OFFSET)),
                                       rx_byte);
        if (idx < len) begin
          idx_next = idx + LEN_W'(1);
        end else begin
          state_next       = HUNT;
          res_fire         = step;
          res.frame_status = status;
          if (status == rfsd_pkg::ST_RECORD) begin
            res.sensor_number = id_next;
            res.first_value   = w1_next;
            res.second_value  = w2_next;
            res.battery_value = wb_next;
          end
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HUNT;
    end else if (step) begin
      state <= state_next;
    end
  end

  // frame data registers
  always_ff @(posedge clk) begin
    if (step) begin
      hi_nz  <= hi_nz_next;
      len    <= len_next;
      idx    <= idx_next;
      sum    <= sum_next;
      type_b <= type_next;
      id_b   <= id_next;
      w1     <= w1_next;
      w2     <= w2_next;
      wb     <= wb_next;
    end
  end

  // a result always returns the parser to hunting
  a_result_hunts: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> state == HUNT)
    else $error("parser did not resume hunting after a result");

  // the data index never runs past the frame length
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    state == DATA |-> idx <= len)
    else $error("data index past frame length");

  // only a good record carries field values
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_fire && res.frame_status != rfsd_pkg::ST_RECORD |->
      res.sensor_number == 8'd0 && res.first_value == 32'd0 &&
      res.second_value == 32'd0 && res.battery_value == 32'd0)
    else $error("non-record result carries field data");

endmodule

// File: bench/testbench.sv
module testbench;

  localparam int MAX_FRAME_BYTES = 100;
  localparam int MAX_LEN         = MAX_FRAME_BYTES - 4;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 3000;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [rfsd_pkg::CFG_DATA_W-1:0] cfg_data;

  rfsd_byte_if   rx();
  rfsd_result_if res();

  radio_frame_sensor_decoder #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) dut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the decoder registers and parse state
  rfsd_pkg::cfg_t regs = '{8'd144, 7'd36, 9'd16};
  logic        p_open = 1'b0;
  logic [6:0]  p_pos = '0;
  logic [15:0] p_len = 16'(MAX_FRAME_BYTES);
  logic [7:0]  p_sum = '0;
  logic [7:0]  p_kind = '0;
  logic [7:0]  p_id = '0;
  logic [31:0] p_one = '0;
  logic [31:0] p_two = '0;
  logic [31:0] p_bat = '0;

  rfsd_pkg::result_t expected_frames[$];
  int      mismatch_count = 0;
  int      frame_bytes = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  logic    hold_go;
  int      quiet_cycles = 0;

  // back to hunting for a delimiter
  function automatic void drop_frame();
    p_open = 1'b0;
    p_pos  = '0;
    p_len  = 16'(MAX_FRAME_BYTES);
  endfunction

  // advance the expected parse by one accepted byte
  function automatic void parse_byte(input logic [7:0] b);
    logic [6:0] d;
    rfsd_pkg::result_t r;
    r = '0;
    if (!p_open) begin
      if (b == rfsd_pkg::DELIMITER) begin
        p_open = 1'b1;
        p_pos  = 7'd1;
        p_sum  = '0;
        p_kind = '0;
        p_id   = '0;
        p_one  = '0;
        p_two  = '0;
        p_bat  = '0;
      end
      return;
    end
    if (p_pos == 7'd1) begin
      p_len = {b, 8'h00};
      p_pos = 7'd2;
      return;
    end
    if (p_pos == 7'd2) begin
      p_len[7:0] = b;
      if (p_len == 16'd0) begin
        drop_frame();
      end else if (p_len > 16'(MAX_LEN)) begin
        drop_frame();
        r.frame_status = rfsd_pkg::ST_OVERLONG;
        expected_frames.push_back(r);
      end else begin
        p_pos = 7'd3;
      end
      return;
    end

    // data or checksum byte
    d = p_pos - 7'd3;
    p_sum = p_sum + b;
    if (d == 7'd0)
      p_kind = b;
    else if (d == rfsd_pkg::ID_OFFSET)
      p_id = b;
    else if (d >= rfsd_pkg::ONE_OFFSET && d < rfsd_pkg::ONE_OFFSET + 4)
      p_one[8*(d - rfsd_pkg::ONE_OFFSET) +: 8] = b;
    else if (d >= rfsd_pkg::TWO_OFFSET && d < rfsd_pkg::TWO_OFFSET + 4)
      p_two[8*(d - rfsd_pkg::TWO_OFFSET) +: 8] = b;
    else if (d >= rfsd_pkg::BAT_OFFSET && d < rfsd_pkg::BAT_OFFSET + 4)
      p_bat[8*(d - rfsd_pkg::BAT_OFFSET) +: 8] = b;
    if (16'(d) < p_len) begin
      p_pos = p_pos + 7'd1;
      return;
    end

    // checksum byte: status in priority order
    if (p_sum != rfsd_pkg::SUM_GOOD) r.frame_status = rfsd_pkg::ST_CHECKSUM;
    else if (p_kind != regs.expected_frame_type) r.frame_status = rfsd_pkg::ST_TYPE;
    else if (p_len != 16'(regs.expected_record_length)) r.frame_status = rfsd_pkg::ST_LENGTH;
    else if ({1'b0, p_id} >= regs.sensor_id_limit) r.frame_status = rfsd_pkg::ST_BAD_ID;
    else begin
      r.frame_status  = rfsd_pkg::ST_RECORD;
      r.sensor_number = p_id;
      r.first_value   = p_one;
      r.second_value  = p_two;
      r.battery_value = p_bat;
    end
    expected_frames.push_back(r);
    drop_frame();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    rfsd_pkg::result_t want;
    if (!rst && res.valid && res.ready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected result beat, status", 32'(res.frame_status), '0);
      end else begin
        want = expected_frames.pop_front();
        if (res.frame_status !== want.frame_status)
          report_mismatch("frame_status", 32'(res.frame_status), 32'(want.frame_status));
        if (res.sensor_number !== want.sensor_number)
          report_mismatch("sensor_number", 32'(res.sensor_number), 32'(want.sensor_number));
        if (res.first_value !== want.first_value)
          report_mismatch("first_value", res.first_value, want.first_value);
        if (res.second_value !== want.second_value)
          report_mismatch("second_value", res.second_value, want.second_value);
        if (res.battery_value !== want.battery_value)
          report_mismatch("battery_value", res.battery_value, want.battery_value);
      end
    end
  end

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    int hold_left;
    if (hold_go) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one byte, with random gaps, until it is taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    if (p_open || b == rfsd_pkg::DELIMITER) frame_bytes++;
    parse_byte(b);
  endtask

  task automatic send_header(input logic [15:0] len);
    send_byte(rfsd_pkg::DELIMITER);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  // whole frame: random filler with the record fields placed where they fit
  task automatic send_frame(input logic [15:0] len, input logic [7:0] kind,
                            input logic [7:0] id, input logic [31:0] w1,
                            input logic [31:0] w2, input logic [31:0] wb,
                            input bit corrupt);
    logic [7:0] body[$];
    logic [7:0] sum;
    int         i;
    body = {};
    sum  = '0;
    for (i = 0; i < len; i++) body.push_back(8'($urandom_range(255)));
    if (len > 0) body[0] = kind;
    if (len > rfsd_pkg::ID_OFFSET) body[rfsd_pkg::ID_OFFSET] = id;
    for (i = 0; i < 4; i++) begin
      if (rfsd_pkg::ONE_OFFSET + i < len) body[rfsd_pkg::ONE_OFFSET + i] = w1[8*i +: 8];
      if (rfsd_pkg::TWO_OFFSET + i < len) body[rfsd_pkg::TWO_OFFSET + i] = w2[8*i +: 8];
      if (rfsd_pkg::BAT_OFFSET + i < len) body[rfsd_pkg::BAT_OFFSET + i] = wb[8*i +: 8];
    end
    foreach (body[k]) sum = sum + body[k];
    sum = rfsd_pkg::SUM_GOOD - sum;
    if (corrupt) sum = sum + 8'($urandom_range(1, 255));
    send_header(len);
    foreach (body[k]) send_byte(body[k]);
    send_byte(sum);
  endtask

  // sender pauses until every expected result has come, then lets the block settle
  task automatic wait_results_done();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [rfsd_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rfsd_pkg::REG_FRAME_TYPE:    regs.expected_frame_type    = value[7:0];
      rfsd_pkg::REG_RECORD_LENGTH: regs.expected_record_length = value[6:0];
      rfsd_pkg::REG_ID_LIMIT:      regs.sensor_id_limit        = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // close any open frame, drain, then reprogram all registers
  task automatic set_config(input logic [7:0] kind, input logic [6:0] rec_len,
                            input logic [8:0] id_limit);
    while (p_open) send_byte(8'h00);
    wait_results_done();
    write_reg(rfsd_pkg::REG_FRAME_TYPE, {1'b0, kind});
    write_reg(rfsd_pkg::REG_RECORD_LENGTH, {2'b00, rec_len});
    write_reg(rfsd_pkg::REG_ID_LIMIT, id_limit);
  endtask

  // mostly well-formed frames, the rest broken or noise
  task automatic send_random_frame();
    int          pick;
    int          id_top;
    logic [15:0] rec_len;
    logic [7:0]  kind;
    logic [7:0]  id;
    pick    = $urandom_range(99);
    kind    = regs.expected_frame_type;
    rec_len = (regs.expected_record_length >= 1 && regs.expected_record_length <= MAX_LEN) ?
              16'(regs.expected_record_length) : 16'd36;
    id_top  = (regs.sensor_id_limit == 0) ? 255 :
              (regs.sensor_id_limit > 256) ? 255 : int'(regs.sensor_id_limit) - 1;
    id      = 8'($urandom_range(id_top));
    if (pick < 40) begin
      send_frame(rec_len, kind, id, $urandom(), $urandom(), $urandom(), 1'b0);
    end else if (pick < 50) begin
      send_frame(rec_len, kind, 8'($urandom_range(255)), $urandom(), $urandom(),
                 $urandom(), 1'b0);
    end else if (pick < 60) begin
      send_frame(rec_len, kind, id, $urandom(), $urandom(), $urandom(), 1'b1);
    end else if (pick < 68) begin
      send_frame(rec_len, 8'($urandom_range(255)), id, $urandom(), $urandom(),
                 $urandom(), 1'b0);
    end else if (pick < 80) begin
      send_frame(16'($urandom_range(1, MAX_LEN)), ($urandom_range(1) ? kind :
                 8'($urandom_range(255))), id, $urandom(), $urandom(), $urandom(),
                 ($urandom_range(9) == 0));
    end else if (pick < 86) begin
      send_frame(16'($urandom_range(1, 40)), kind, id, $urandom(), $urandom(),
                 $urandom(), 1'b0);
    end else if (pick < 92) begin
      send_header(16'($urandom_range(MAX_LEN + 1, 65535)));
    end else if (pick < 95) begin
      send_header(16'd0);
    end else if (pick < 98) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
    end else begin
      // frame cut short: the next delimiter lands inside it as data
      send_header(16'($urandom_range(1, MAX_LEN)));
      repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(255)));
    end
  endtask

  // status codes, field extremes and header cases at reset settings
  task automatic test_hunting_and_status();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_frame(16'd36, 8'h90, 8'd15, 32'h0403_0201, 32'hFFFF_FFFF, 32'h8000_0001, 1'b0);
    send_frame(16'd36, 8'h90, 8'd0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_frame(16'd36, 8'h90, 8'd3, $urandom(), $urandom(), $urandom(), 1'b1);
    send_frame(16'd36, 8'h91, 8'd3, $urandom(), $urandom(), $urandom(), 1'b0);
    send_frame(16'd35, 8'h90, 8'd2, $urandom(), $urandom(), $urandom(), 1'b0);
    send_frame(16'd36, 8'h90, 8'd16, $urandom(), $urandom(), $urandom(), 1'b0);
    send_frame(16'd36, 8'h90, 8'd255, $urandom(), $urandom(), $urandom(), 1'b0);
    // delimiter bytes inside the data
    send_frame(16'd36, 8'h90, 8'd7, 32'h7E7E_7E7E, 32'h007E_0000, $urandom(), 1'b0);
    send_header(16'd0);
    send_header(16'(MAX_LEN + 1));
    send_header(16'hFFFF);
    send_header(16'h0100);
    send_frame(16'(MAX_LEN), 8'h90, 8'd1, $urandom(), $urandom(), $urandom(), 1'b0);
    send_frame(16'd1, 8'h90, 8'd1, 32'h0, 32'h0, 32'h0, 1'b0);
  endtask

  // short records: fields past the checksum read zero, checksum lands on the id
  task automatic test_short_frames();
    set_config(8'h90, 7'd12, 9'd256);
    send_frame(16'd12, 8'h90, 8'd0, $urandom(), $urandom(), $urandom(), 1'b0);
    send_frame(16'd12, 8'h90, 8'd0, $urandom(), $urandom(), $urandom(), 1'b0);
    set_config(8'h90, 7'd18, 9'd256);
    send_frame(16'd18, 8'h90, 8'd200, 32'hA5A5_A5A5, $urandom(), $urandom(), 1'b0);
    set_config(8'h90, 7'd33, 9'd256);
    send_frame(16'd33, 8'h90, 8'd255, $urandom(), $urandom(), $urandom(), 1'b0);
  endtask

  // long receiver hold-off fills the block, then a mid-stream drain
  task automatic test_backpressure();
    set_config(8'h90, 7'd1, 9'd256);
    gap_pct = 0;
    stall_pct <= 0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (12) send_frame(16'd1, 8'h90, 8'd0, 32'h0, 32'h0, 32'h0, 1'b0);
    repeat (4) send_header(16'hFFFF);
    wait_results_done();
    repeat (6) send_frame(16'd1, 8'h90, 8'd0, 32'h0, 32'h0, 32'h0, $urandom_range(1));
  endtask

  task automatic run_random_phase(input int send_gap, input int recv_stall, input int bytes);
    int start;
    gap_pct = send_gap;
    stall_pct <= recv_stall;
    start = frame_bytes;
    while (frame_bytes - start < bytes) send_random_frame();
  endtask

  // register settings from one extreme to the other under each idling pattern
  task automatic test_random_traffic();
    set_config(8'd144, 7'd36, 9'd16);
    run_random_phase(0, 0, 140);
    set_config(8'h00, 7'd1, 9'd1);
    run_random_phase(50, 0, 140);
    set_config(8'hFF, 7'(MAX_LEN), 9'd256);
    run_random_phase(0, 50, 140);
    set_config(rfsd_pkg::DELIMITER, 7'd127, 9'd0);
    run_random_phase(8, 8, 140);
    set_config(8'($urandom_range(255)), 7'($urandom_range(1, MAX_LEN)),
               9'($urandom_range(1, 256)));
    run_random_phase(8, 8, 140);
    set_config(8'h90, 7'd0, 9'd511);
    run_random_phase(0, 0, 140);
  endtask

  initial begin
    rx.valid   <= 1'b0;
    rx.rx_byte <= 8'h00;
    cfg_we     <= 1'b0;
    cfg_index  <= rfsd_pkg::REG_FRAME_TYPE;
    cfg_data   <= '0;
    hold_go    <= 1'b0;
    rst        <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_hunting_and_status();
    test_short_frames();
    test_backpressure();
    test_random_traffic();
    wait_results_done();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/rfsd_pkg.sv
design/rfsd_if.sv
design/rfsd_cfg_regs.sv
design/rfsd_parser.sv
design/radio_frame_sensor_decoder.sv
bench/testbench.sv
